FILE: rtl/core/bbsc_pkg.sv
// Shared types, constants and helpers for the beat/bar show clock.
package bbsc_pkg;

	localparam int NUM_SCENES = 8;

	localparam int DIV_W = 40;
	localparam int DVS_W = 16;
	localparam int DIV_CNT_W = $clog2(DIV_W);

	localparam logic [DIV_W-1:0] MINUTE_MS = DIV_W'(60000);

	localparam logic [1:0] ACT_TICK   = 2'd0;
	localparam logic [1:0] ACT_BUTTON = 2'd1;
	localparam logic [1:0] ACT_TEMPO  = 2'd2;

	localparam logic [1:0] KIND_STATUS = 2'd0;
	localparam logic [1:0] KIND_SCENE  = 2'd1;
	localparam logic [1:0] KIND_SYNC   = 2'd2;

	localparam logic [1:0] REG_BEATS_PER_BAR = 2'd0;
	localparam logic [1:0] REG_SCENE_REFRESH = 2'd1;
	localparam logic [1:0] REG_DOT_FLASH     = 2'd2;

	typedef struct packed {
		logic             start;
		logic [DIV_W-1:0] dividend;
		logic [DVS_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [DIV_W-1:0] quotient;
	} div_rsp_t;

	// A deadline has passed when the wrapped distance from it is below half the range.
	function automatic logic reached(input logic [31:0] now, input logic [31:0] deadline);
		logic [31:0] diff;
		diff = now - deadline;
		return ~diff[31];
	endfunction

endpackage

FILE: rtl/core/bbsc_div.sv
// Restoring divider, one quotient bit per cycle, shared by the sequencer.
module bbsc_div (
	input  logic              clk,
	input  logic              arst_n,
	input  bbsc_pkg::div_req_t req,
	output bbsc_pkg::div_rsp_t rsp
);
	import bbsc_pkg::*;

	logic [DIV_W-1:0]     dvd_q;
	logic [DVS_W-1:0]     rem_q;
	logic [DVS_W-1:0]     dvs_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;

	logic [DVS_W:0] trial;
	logic [DVS_W:0] diff;
	logic           fits;

	assign trial = {rem_q, dvd_q[DIV_W-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(DIV_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.dividend;
			dvs_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DIV_W-2:0], fits};
			rem_q <= fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = dvd_q;

endmodule

FILE: rtl/core/beat_bar_show_clock.sv
// Beat/bar show clock: millisecond-timestamped tempo clock with scene and sync messages.
//
// Each request on the slave stream is one timestamped event (tick, button click or
// tempo update). The block answers with one to three result requests on the master
// stream: optional clock-sync and scene-select messages followed by one status
// result, which alone carries tlast. Requests are handled one at a time: tready is
// high only while the sequencer is idle. The single shared restoring divider does the
// slow work: a request can use it once for the beat interval (60000 / bpm), when it
// re-arms the beat deadline, and once for the flash brightness (remaining * 255 /
// flash length), when the flash is still lit afterwards. Each pass loads the
// operands, shifts out the quotient bit by bit and then hands the quotient over.
// Each message waits for room in the result register, so any backpressure on the
// master side holds the sequencer. The result register lets the next request be
// taken while the final status result still waits to be read.
// Configuration writes are taken at any cycle with cfg_we high and should only be
// issued while the block is idle.
module beat_bar_show_clock (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// now_ms[31:0], new_bpm[40:32], resync[41], onset_ms[73:42], zero fill up to 80 bits
	input  logic [79:0] s_axis_tdata,
	// action[1:0]
	input  logic [1:0]  s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// scene[7:0], tempo[16:8], beat_number[21:17], bar_count[53:22], dot_visible[54],
	// dot_is_sync[55], pulse[63:56], running[64], zero fill up to 72 bits
	output logic [71:0] m_axis_tdata,
	// kind[1:0]
	output logic [1:0]  m_axis_tuser,
	output logic        m_axis_tlast
);
	import bbsc_pkg::*;

	localparam logic [3:0] S_IDLE     = 4'd0;
	localparam logic [3:0] S_MSG1     = 4'd1;
	localparam logic [3:0] S_UPD      = 4'd2;
	localparam logic [3:0] S_MSG2     = 4'd3;
	localparam logic [3:0] S_IVL_GO   = 4'd4;
	localparam logic [3:0] S_IVL_WAIT = 4'd5;
	localparam logic [3:0] S_PUL_GO   = 4'd6;
	localparam logic [3:0] S_PUL_WAIT = 4'd7;
	localparam logic [3:0] S_STAT     = 4'd8;

	localparam logic [7:0] SCENE_MAX = 8'(NUM_SCENES - 1);

	// Configuration registers.
	logic [4:0]  bpb_q;
	logic [31:0] refresh_q;
	logic [15:0] flash_len_q;

	// Show state.
	logic        show_on_q;
	logic [31:0] bar_q;
	logic [4:0]  pos_q;
	logic [8:0]  bpm_q;
	logic [31:0] beat_dl_q;
	logic [31:0] scene_dl_q;
	logic [31:0] flash_dl_q;
	logic        flash_sync_q;
	logic [7:0]  scene_q;

	// Current request.
	logic [1:0]  act_q;
	logic [31:0] now_q;
	logic [8:0]  new_bpm_q;
	logic        resync_q;
	logic [31:0] onset_q;

	// Sequencer.
	logic [3:0]  state_q;
	logic        scene_pend_q;
	logic        sync_pend_q;
	logic        ivl_need_q;
	logic [31:0] ivl_base_q;
	logic        vis_q;
	logic [7:0]  pulse_q;

	// Result register.
	logic        out_valid_q;
	logic [1:0]  out_kind_q;
	logic [64:0] out_data_q;
	logic        out_last_q;

	div_req_t div_req;
	div_rsp_t div_rsp;

	logic        slot_free;
	logic        emit;
	logic [1:0]  emit_kind;
	logic        emit_vis;
	logic [7:0]  emit_pulse;
	logic        emit_last;
	logic [4:0]  bar_len;
	logic        beat_hit;
	logic        flash_on;
	logic [31:0] flash_rem;
	logic [31:0] flash_end;
	logic [DVS_W-1:0] flash_div;
	logic        accept;

	assign slot_free     = !out_valid_q || m_axis_tready;
	assign s_axis_tready = (state_q == S_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;

	// A bar of zero beats acts as one, anything above sixteen as sixteen.
	assign bar_len   = (bpb_q == 5'd0) ? 5'd1 : ((bpb_q > 5'd16) ? 5'd16 : bpb_q);
	assign beat_hit  = show_on_q && reached(now_q, beat_dl_q);
	assign flash_on  = show_on_q && !reached(now_q, flash_dl_q);
	assign flash_rem = flash_dl_q - now_q;
	assign flash_end = now_q + {16'd0, flash_len_q};
	assign flash_div = (flash_len_q == 16'd0) ? DVS_W'(1) : flash_len_q;

	// Both divider jobs are driven from the sequencer state.
	always_comb begin
		div_req.start    = 1'b0;
		div_req.dividend = MINUTE_MS;
		div_req.divisor  = DVS_W'(bpm_q);
		if (state_q == S_IVL_GO) begin
			div_req.start = 1'b1;
		end else if (state_q == S_PUL_GO) begin
			div_req.start    = flash_on;
			// remaining * 255 as remaining * 256 - remaining
			div_req.dividend = {flash_rem, 8'd0} - {8'd0, flash_rem};
			div_req.divisor  = flash_div;
		end
	end

	bbsc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Which result goes into the output register this cycle.
	always_comb begin
		emit       = 1'b0;
		emit_kind  = KIND_STATUS;
		emit_vis   = 1'b0;
		emit_pulse = 8'd0;
		emit_last  = 1'b0;
		case (state_q)
			S_MSG1: begin
				if (act_q == ACT_TICK && beat_hit && pos_q == 5'd1) begin
					emit      = slot_free;
					emit_kind = KIND_SYNC;
				end
			end
			S_MSG2: begin
				if (scene_pend_q) begin
					emit      = slot_free;
					emit_kind = KIND_SCENE;
				end else if (sync_pend_q) begin
					emit      = slot_free;
					emit_kind = KIND_SYNC;
				end
			end
			S_STAT: begin
				emit       = slot_free;
				emit_kind  = KIND_STATUS;
				emit_vis   = vis_q;
				emit_pulse = pulse_q;
				emit_last  = 1'b1;
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_kind_q <= emit_kind;
			out_last_q <= emit_last;
			out_data_q <= {show_on_q, emit_pulse, flash_sync_q & emit_last, emit_vis,
				bar_q, pos_q, bpm_q, scene_q};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_kind_q;
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tdata  = {7'd0, out_data_q};

	// Configuration writes; an index past the list is ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bpb_q       <= 5'd4;
			refresh_q   <= 32'd30000;
			flash_len_q <= 16'd140;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_BEATS_PER_BAR: bpb_q       <= cfg_data[4:0];
				REG_SCENE_REFRESH: refresh_q   <= cfg_data;
				REG_DOT_FLASH:     flash_len_q <= cfg_data[15:0];
				default:           bpb_q       <= bpb_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			act_q     <= s_axis_tuser;
			now_q     <= s_axis_tdata[31:0];
			new_bpm_q <= s_axis_tdata[40:32];
			resync_q  <= s_axis_tdata[41];
			onset_q   <= s_axis_tdata[73:42];
		end
	end

	// Sequencer and show state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			show_on_q    <= 1'b0;
			bar_q        <= 32'd1;
			pos_q        <= 5'd1;
			bpm_q        <= 9'd120;
			beat_dl_q    <= 32'd0;
			scene_dl_q   <= 32'd0;
			flash_dl_q   <= 32'd0;
			flash_sync_q <= 1'b0;
			scene_q      <= 8'd0;
			scene_pend_q <= 1'b0;
			sync_pend_q  <= 1'b0;
			ivl_need_q   <= 1'b0;
			ivl_base_q   <= 32'd0;
			vis_q        <= 1'b0;
			pulse_q      <= 8'd0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						scene_pend_q <= 1'b0;
						sync_pend_q  <= 1'b0;
						ivl_need_q   <= 1'b0;
						state_q      <= S_MSG1;
					end
				end
				S_MSG1: begin
					// The sync on beat one of a tick shows the state before the beat advances.
					if (!(act_q == ACT_TICK && beat_hit && pos_q == 5'd1) || slot_free) begin
						state_q <= S_UPD;
					end
				end
				S_UPD: begin
					state_q <= S_MSG2;
					case (act_q)
						ACT_TICK: begin
							if (beat_hit) begin
								if (pos_q >= bar_len) begin
									pos_q <= 5'd1;
									bar_q <= bar_q + 32'd1;
								end else begin
									pos_q <= pos_q + 5'd1;
								end
								flash_dl_q   <= flash_end;
								flash_sync_q <= 1'b0;
								ivl_need_q   <= 1'b1;
								ivl_base_q   <= now_q;
							end
							if (show_on_q && reached(now_q, scene_dl_q)) begin
								scene_pend_q <= 1'b1;
								scene_dl_q   <= now_q + refresh_q;
							end
						end
						ACT_BUTTON: begin
							scene_pend_q <= 1'b1;
							scene_dl_q   <= now_q + refresh_q;
							if (show_on_q) begin
								scene_q <= (scene_q == SCENE_MAX) ? 8'd0 : scene_q + 8'd1;
							end else begin
								// Show start: restart the bar and flash as a sync.
								show_on_q    <= 1'b1;
								bar_q        <= 32'd1;
								pos_q        <= 5'd1;
								ivl_need_q   <= 1'b1;
								ivl_base_q   <= now_q;
								sync_pend_q  <= 1'b1;
								flash_dl_q   <= flash_end;
								flash_sync_q <= 1'b1;
							end
						end
						ACT_TEMPO: begin
							bpm_q <= (new_bpm_q == 9'd0) ? 9'd1 : new_bpm_q;
							if (resync_q) begin
								pos_q        <= 5'd1;
								bar_q        <= bar_q + 32'd1;
								ivl_need_q   <= 1'b1;
								ivl_base_q   <= onset_q;
								sync_pend_q  <= 1'b1;
								flash_dl_q   <= flash_end;
								flash_sync_q <= 1'b1;
							end
						end
						default: begin
							state_q <= S_MSG2;
						end
					endcase
				end
				S_MSG2: begin
					if (scene_pend_q) begin
						if (slot_free) begin
							scene_pend_q <= 1'b0;
						end
					end else if (sync_pend_q) begin
						if (slot_free) begin
							sync_pend_q <= 1'b0;
						end
					end else begin
						state_q <= ivl_need_q ? S_IVL_GO : S_PUL_GO;
					end
				end
				S_IVL_GO: begin
					state_q <= S_IVL_WAIT;
				end
				S_IVL_WAIT: begin
					if (div_rsp.done) begin
						beat_dl_q <= ivl_base_q + {16'd0, div_rsp.quotient[15:0]};
						state_q   <= S_PUL_GO;
					end
				end
				S_PUL_GO: begin
					vis_q   <= flash_on;
					pulse_q <= 8'd0;
					state_q <= flash_on ? S_PUL_WAIT : S_STAT;
				end
				S_PUL_WAIT: begin
					if (div_rsp.done) begin
						// Saturate a ratio above full brightness.
						pulse_q <= (|div_rsp.quotient[DIV_W-1:8]) ? 8'hFF :
							div_rsp.quotient[7:0];
						state_q <= S_STAT;
					end
				end
				S_STAT: begin
					if (slot_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTH
	a_last_is_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser == KIND_STATUS)))
		else $error("tlast does not match a status result");

	a_msg_no_dot: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tlast) |-> (m_axis_tdata[63:54] == 10'd0))
		else $error("message result carries dot fields");

	a_div_done_waiting: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == S_IVL_WAIT || state_q == S_PUL_WAIT))
		else $error("divider finished outside a wait state");

	a_beat_range: assert property (@(posedge clk) disable iff (!arst_n)
		(pos_q != 5'd0) && (pos_q <= 5'd16))
		else $error("beat position out of range");

	a_scene_range: assert property (@(posedge clk) disable iff (!arst_n)
		scene_q <= SCENE_MAX)
		else $error("scene index out of range");
`endif

endmodule

FILE: dv/beat_bar_show_clock_tb.sv
// Self-checking testbench for the beat/bar show clock: directed and random requests.
module beat_bar_show_clock_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import bbsc_pkg::*;

	// Action code and register index that the block has to ignore.
	localparam logic [1:0] ACT_UNUSED = 2'd3;
	localparam logic [1:0] REG_UNUSED = 2'd3;

	localparam logic [31:0] MINUTE = 32'd60000;
	localparam logic [63:0] FULL_PULSE = 64'd255;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  scene;
		logic [8:0]  tempo;
		logic [4:0]  beat;
		logic [31:0] bar;
		logic        dot_visible;
		logic        dot_is_sync;
		logic [7:0]  pulse;
		logic        running;
		logic        last;
	} show_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [31:0] cfg_data = '0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [79:0] s_axis_tdata = '0;
	logic [1:0]  s_axis_tuser = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [71:0] m_axis_tdata;
	logic [1:0]  m_axis_tuser;
	logic        m_axis_tlast;

	beat_bar_show_clock dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	always #2 clk = ~clk;

	// Predicted show clock: registers and state as they stand after the last
	// accepted request.
	logic [4:0]  cfg_beats_per_bar = 5'd4;
	logic [31:0] cfg_scene_refresh = 32'd30000;
	logic [15:0] cfg_dot_flash = 16'd140;

	logic        show_running = 1'b0;
	logic [31:0] bar_total = 32'd1;
	logic [4:0]  beat_in_bar = 5'd1;
	logic [8:0]  tempo_bpm = 9'd120;
	logic [31:0] beat_due = '0;
	logic [31:0] scene_due = '0;
	logic [31:0] flash_due = '0;
	logic        flash_from_sync = 1'b0;
	logic [7:0]  scene_idx = '0;

	show_result_t expected_results[$];

	// Sender and receiver idle at random unless the running phase asks for a
	// stretch of back-to-back traffic.
	bit tx_calm = 1'b0;
	bit rx_calm = 1'b0;

	int mismatch_count = 0;
	int requests_sent = 0;
	int results_seen = 0;
	int sync_seen = 0;
	int scene_seen = 0;
	int settings_applied = 0;
	logic [31:0] show_ms = '0;

	function automatic bit deadline_passed(input logic [31:0] now, input logic [31:0] due);
		logic [31:0] gap;
		gap = now - due;
		return gap[31] == 1'b0;
	endfunction

	function automatic logic [31:0] beat_period_ms();
		return MINUTE / {23'd0, tempo_bpm};
	endfunction

	function automatic logic [4:0] bar_length();
		if (cfg_beats_per_bar == 5'd0) return 5'd1;
		if (cfg_beats_per_bar > 5'd16) return 5'd16;
		return cfg_beats_per_bar;
	endfunction

	function automatic void queue_result(input logic [1:0] kind, input logic vis,
		input logic sync, input logic [7:0] pulse, input logic last);
		show_result_t r;
		r.kind = kind;
		r.scene = scene_idx;
		r.tempo = tempo_bpm;
		r.beat = beat_in_bar;
		r.bar = bar_total;
		r.dot_visible = vis;
		r.dot_is_sync = sync;
		r.pulse = pulse;
		r.running = show_running;
		r.last = last;
		expected_results.push_back(r);
	endfunction

	// Advances the predicted clock by one request and queues what it sends out.
	function automatic void predict_request(input logic [1:0] act, input logic [31:0] now,
		input logic [8:0] nbpm, input logic rs, input logic [31:0] onset);
		logic [63:0] ratio;
		logic [63:0] divisor;
		logic        vis;
		logic [7:0]  pulse;
		vis = 1'b0;
		pulse = '0;
		case (act)
		ACT_TICK: begin
			if (show_running) begin
				if (deadline_passed(now, beat_due)) begin
					// Beat one of a bar announces the bar before it moves on.
					if (beat_in_bar == 5'd1) queue_result(KIND_SYNC, 1'b0, 1'b0, 8'd0, 1'b0);
					if (beat_in_bar >= bar_length()) begin
						beat_in_bar = 5'd1;
						bar_total = bar_total + 32'd1;
					end else begin
						beat_in_bar = beat_in_bar + 5'd1;
					end
					flash_due = now + {16'd0, cfg_dot_flash};
					flash_from_sync = 1'b0;
					beat_due = now + beat_period_ms();
				end
				if (deadline_passed(now, scene_due)) begin
					queue_result(KIND_SCENE, 1'b0, 1'b0, 8'd0, 1'b0);
					scene_due = now + cfg_scene_refresh;
				end
			end
		end
		ACT_BUTTON: begin
			if (show_running) begin
				scene_idx = 8'((32'(scene_idx) + 32'd1) % NUM_SCENES);
				queue_result(KIND_SCENE, 1'b0, 1'b0, 8'd0, 1'b0);
				scene_due = now + cfg_scene_refresh;
			end else begin
				// First click starts the show from bar one.
				show_running = 1'b1;
				bar_total = 32'd1;
				beat_in_bar = 5'd1;
				beat_due = now + beat_period_ms();
				scene_due = now + cfg_scene_refresh;
				queue_result(KIND_SCENE, 1'b0, 1'b0, 8'd0, 1'b0);
				queue_result(KIND_SYNC, 1'b0, 1'b0, 8'd0, 1'b0);
				flash_due = now + {16'd0, cfg_dot_flash};
				flash_from_sync = 1'b1;
			end
		end
		ACT_TEMPO: begin
			// A tempo of zero is taken as one beat per minute.
			tempo_bpm = (nbpm == 9'd0) ? 9'd1 : nbpm;
			if (rs) begin
				beat_in_bar = 5'd1;
				bar_total = bar_total + 32'd1;
				beat_due = onset + beat_period_ms();
				queue_result(KIND_SYNC, 1'b0, 1'b0, 8'd0, 1'b0);
				flash_due = now + {16'd0, cfg_dot_flash};
				flash_from_sync = 1'b1;
			end
		end
		default: begin
		end
		endcase

		if (show_running && !deadline_passed(now, flash_due)) begin
			divisor = (cfg_dot_flash == 16'd0) ? 64'd1 : {48'd0, cfg_dot_flash};
			ratio = {32'd0, flash_due - now} * FULL_PULSE / divisor;
			vis = 1'b1;
			// A request stamped before the flash started can push the ratio past full.
			pulse = (ratio > FULL_PULSE) ? 8'd255 : ratio[7:0];
		end
		queue_result(KIND_STATUS, vis, flash_from_sync, pulse, 1'b1);
	endfunction

	// Drives one request and waits until the block takes it. Valid stays high on
	// return so that a following request can go out on the very next cycle.
	task automatic send_request(input logic [1:0] act, input logic [31:0] now,
		input logic [8:0] nbpm, input logic rs, input logic [31:0] onset);
		if (!tx_calm) begin
			while ($urandom_range(0, 99) < 10) begin
				s_axis_tvalid <= 1'b0;
				@(posedge clk);
			end
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {6'd0, onset, rs, nbpm, now};
		s_axis_tuser <= act;
		do @(posedge clk); while (!s_axis_tready);
		predict_request(act, now, nbpm, rs, onset);
		requests_sent++;
	endtask

	// Lets the block run dry: no request pending and every result read.
	task automatic wait_for_results();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (expected_results.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic write_register(input logic [1:0] idx, input logic [31:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
		REG_BEATS_PER_BAR: cfg_beats_per_bar = value[4:0];
		REG_SCENE_REFRESH: cfg_scene_refresh = value;
		REG_DOT_FLASH:     cfg_dot_flash = value[15:0];
		default: begin
		end
		endcase
		@(posedge clk);
	endtask

	task automatic apply_settings(input logic [31:0] bpb, input logic [31:0] refresh,
		input logic [31:0] flash_ms);
		wait_for_results();
		write_register(REG_BEATS_PER_BAR, bpb);
		write_register(REG_SCENE_REFRESH, refresh);
		write_register(REG_DOT_FLASH, flash_ms);
		settings_applied++;
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (want !== got) begin
			mismatch_count++;
			$display("%0t ns: %s mismatch, expected %0d (0x%0h), actual %0d (0x%0h)",
				$time, name, want, want, got, got);
		end
	endtask

	// Result side: every accepted result is held against the oldest prediction.
	always @(posedge clk) begin
		show_result_t got;
		show_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.kind = m_axis_tuser;
			got.scene = m_axis_tdata[7:0];
			got.tempo = m_axis_tdata[16:8];
			got.beat = m_axis_tdata[21:17];
			got.bar = m_axis_tdata[53:22];
			got.dot_visible = m_axis_tdata[54];
			got.dot_is_sync = m_axis_tdata[55];
			got.pulse = m_axis_tdata[63:56];
			got.running = m_axis_tdata[64];
			got.last = m_axis_tlast;
			results_seen++;
			if (got.kind == KIND_SYNC) sync_seen++;
			if (got.kind == KIND_SCENE) scene_seen++;
			if (expected_results.size() == 0) begin
				mismatch_count++;
				$display("%0t ns: unexpected result, expected none, actual kind %0d bar %0d",
					$time, got.kind, got.bar);
			end else begin
				want = expected_results.pop_front();
				check_field("kind", 32'(want.kind), 32'(got.kind));
				check_field("scene", 32'(want.scene), 32'(got.scene));
				check_field("tempo", 32'(want.tempo), 32'(got.tempo));
				check_field("beat_number", 32'(want.beat), 32'(got.beat));
				check_field("bar_count", want.bar, got.bar);
				check_field("dot_visible", 32'(want.dot_visible), 32'(got.dot_visible));
				check_field("dot_is_sync", 32'(want.dot_is_sync), 32'(got.dot_is_sync));
				check_field("pulse", 32'(want.pulse), 32'(got.pulse));
				check_field("running", 32'(want.running), 32'(got.running));
				check_field("tlast", 32'(want.last), 32'(got.last));
			end
		end
	end

	// Receiver backpressure.
	always @(posedge clk) begin
		m_axis_tready <= rx_calm ? 1'b1 : ($urandom_range(0, 99) >= 10);
	end

	// Before the show starts: ticks give only status, the unused action does
	// nothing, a zero tempo becomes one, and a resync still restarts the bar.
	task automatic test_stopped_clock();
		send_request(ACT_TICK, 32'd0, 9'd120, 1'b0, 32'd0);
		send_request(ACT_UNUSED, 32'hFFFF_FFFF, 9'h1FF, 1'b1, 32'hFFFF_FFFF);
		send_request(ACT_TEMPO, 32'd100, 9'd0, 1'b0, 32'd0);
		send_request(ACT_TEMPO, 32'd200, 9'd511, 1'b1, 32'hFFFF_FFF0);
	endtask

	// Starts the show, walks through a bar, flips scenes all the way round and
	// sends one request stamped before the flash began so the pulse saturates.
	task automatic test_show_start();
		logic [31:0] t;
		send_request(ACT_BUTTON, 32'd1000, 9'd0, 1'b0, 32'd0);
		send_request(ACT_TICK, 32'd1050, 9'd0, 1'b0, 32'd0);
		t = 32'd1117;
		for (int i = 0; i < 5; i++) begin
			send_request(ACT_TICK, t, 9'd0, 1'b0, 32'd0);
			t = t + 32'd117;
		end
		send_request(ACT_TEMPO, 32'd1700, 9'd60, 1'b1, 32'd1690);
		send_request(ACT_TICK, 32'd1650, 9'd0, 1'b0, 32'd0);
		send_request(ACT_TICK, 32'd2690, 9'd0, 1'b0, 32'd0);
		for (int i = 0; i < NUM_SCENES; i++)
			send_request(ACT_BUTTON, 32'd2700 + i, 9'd0, 1'b0, 32'd0);
	endtask

	// Registers at and past their limits: a bar of one beat, a zero flash, the
	// shortest and longest refresh, an oversized bar length and a write to an
	// index the block does not have.
	task automatic test_register_extremes();
		logic [31:0] t;
		apply_settings(32'd0, 32'd1, 32'd0);
		t = 32'd100000;
		for (int i = 0; i < 4; i++) begin
			send_request(ACT_TICK, t, 9'd0, 1'b0, 32'd0);
			t = t + 32'd1000;
		end
		send_request(ACT_TICK, t - 32'd1003, 9'd0, 1'b0, 32'd0);
		apply_settings(32'd31, 32'hFFFF_FFFF, 32'd65535);
		write_register(REG_UNUSED, 32'hFFFF_FFFF);
		send_request(ACT_TEMPO, t, 9'd511, 1'b1, t);
		for (int i = 0; i < 18; i++) begin
			t = t + 32'd117;
			send_request(ACT_TICK, t, 9'd0, 1'b0, 32'd0);
		end
		show_ms = t;
	endtask

	// Mostly well-formed traffic: ticks moving forward in time, with clicks,
	// tempo changes, jumps in time and unused actions mixed in.
	task automatic test_random_show(input int count, input logic [31:0] bpb,
		input logic [31:0] refresh, input logic [31:0] flash_ms, input bit calm);
		int pick;
		logic [31:0] onset;
		apply_settings(bpb, refresh, flash_ms);
		tx_calm = calm;
		rx_calm = calm;
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(0, 99);
			if (i == count / 2) wait_for_results();
			if (pick < 70) begin
				show_ms = show_ms + $urandom_range(0, 300);
				send_request(ACT_TICK, show_ms, 9'($urandom), 1'($urandom), $urandom);
			end else if (pick < 78) begin
				show_ms = show_ms + $urandom_range(0, 50);
				send_request(ACT_BUTTON, show_ms, 9'($urandom), 1'($urandom), $urandom);
			end else if (pick < 90) begin
				show_ms = show_ms + $urandom_range(0, 50);
				onset = ($urandom_range(0, 3) == 0) ? $urandom
					: show_ms - $urandom_range(0, 100);
				send_request(ACT_TEMPO, show_ms, 9'($urandom_range(0, 511)), 1'($urandom),
					onset);
			end else if (pick < 95) begin
				show_ms = $urandom;
				send_request(ACT_TICK, show_ms, 9'($urandom), 1'($urandom), $urandom);
			end else begin
				send_request(ACT_UNUSED, $urandom, 9'($urandom), 1'($urandom), $urandom);
			end
		end
		wait_for_results();
		tx_calm = 1'b0;
		rx_calm = 1'b0;
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_stopped_clock();
		test_show_start();
		test_register_extremes();
		test_random_show(44, 32'd4, 32'd2000, 32'd140, 1'b0);
		test_random_show(44, 32'd16, 32'd700, 32'd65535, 1'b0);
		test_random_show(44, 32'd1, 32'd1, 32'd1, 1'b1);
		test_random_show(44, $urandom_range(1, 16), $urandom_range(1, 5000),
			$urandom_range(1, 400), 1'b0);

		wait_for_results();
		repeat (200) @(posedge clk);

		$display("Run covered %0d requests and %0d results (%0d clock-sync, %0d scene-select)",
			requests_sent, results_seen, sync_seen, scene_seen);
		$display("under %0d register settings, with %0d mismatches.",
			settings_applied, mismatch_count);
		if (mismatch_count == 0 && expected_results.size() == 0) begin
			$display("beat_bar_show_clock_tb OK");
		end else begin
			$display("beat_bar_show_clock_tb NOT OK");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest legal run.
	initial begin
		#2_000_000;
		$display("Timeout with %0d results still expected.", expected_results.size());
		$display("beat_bar_show_clock_tb NOT OK");
		$finish;
	end

endmodule

FILE: files.f
rtl/core/bbsc_pkg.sv
rtl/core/bbsc_div.sv
rtl/core/beat_bar_show_clock.sv
dv/beat_bar_show_clock_tb.sv
